/* design/sc2asc_pkg.sv */
// Package for the scan code decoder: key codes, glyph tables and the decode result type.
`default_nettype none

package sc2asc_pkg;

  // Scan codes (set 1) that the decoder treats specially.
  localparam logic [7:0] CodeLshiftMake  = 8'h2A;
  localparam logic [7:0] CodeRshiftMake  = 8'h36;
  localparam logic [7:0] CodeLshiftBreak = 8'hAA;
  localparam logic [7:0] CodeRshiftBreak = 8'hB6;
  localparam logic [7:0] CodeCapsMake    = 8'h3A;

  // Kind codes carried on tuser.
  localparam logic KindAscii = 1'b0;
  localparam logic KindRaw   = 1'b1;

  // Outcome of decoding one scan code against the current modifier flags.
  typedef struct packed {
    logic       has_result;
    logic       kind;
    logic [7:0] value;
    logic       shift_nxt;
    logic       caps_nxt;
  } xlate_res_t;

  // Unshifted glyph of a make code below 0x40; zero means no character.
  function automatic logic [7:0] plain_glyph(input logic [5:0] code);
    logic [7:0] g;
    unique case (code)
      6'h02: g = "1";
      6'h03: g = "2";
      6'h04: g = "3";
      6'h05: g = "4";
      6'h06: g = "5";
      6'h07: g = "6";
      6'h08: g = "7";
      6'h09: g = "8";
      6'h0A: g = "9";
      6'h0B: g = "0";
      6'h0C: g = "-";
      6'h10: g = "q";
      6'h11: g = "w";
      6'h12: g = "e";
      6'h13: g = "r";
      6'h14: g = "t";
      6'h15: g = "y";
      6'h16: g = "u";
      6'h17: g = "i";
      6'h18: g = "o";
      6'h19: g = "p";
      6'h1A: g = "[";
      6'h1B: g = "]";
      6'h1C: g = 8'h0A;
      6'h1E: g = "a";
      6'h1F: g = "s";
      6'h20: g = "d";
      6'h21: g = "f";
      6'h22: g = "g";
      6'h23: g = "h";
      6'h24: g = "j";
      6'h25: g = "k";
      6'h26: g = "l";
      6'h27: g = ";";
      6'h2C: g = "z";
      6'h2D: g = "x";
      6'h2E: g = "c";
      6'h2F: g = "v";
      6'h30: g = "b";
      6'h31: g = "n";
      6'h32: g = "m";
      6'h33: g = ",";
      6'h34: g = ".";
      6'h35: g = "/";
      6'h39: g = " ";
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // Shifted glyph of a make code below 0x40; zero means no character.
  function automatic logic [7:0] shifted_glyph(input logic [5:0] code);
    logic [7:0] g;
    unique case (code)
      6'h02: g = "!";
      6'h03: g = "@";
      6'h04: g = "#";
      6'h05: g = "$";
      6'h06: g = "%";
      6'h07: g = "^";
      6'h08: g = "&";
      6'h09: g = "*";
      6'h0A: g = "(";
      6'h0B: g = ")";
      6'h0C: g = "_";
      6'h10: g = "Q";
      6'h11: g = "W";
      6'h12: g = "E";
      6'h13: g = "R";
      6'h14: g = "T";
      6'h15: g = "Y";
      6'h16: g = "U";
      6'h17: g = "I";
      6'h18: g = "O";
      6'h19: g = "P";
      6'h1A: g = "{";
      6'h1B: g = "}";
      6'h1C: g = 8'h0A;
      6'h1E: g = "A";
      6'h1F: g = "S";
      6'h20: g = "D";
      6'h21: g = "F";
      6'h22: g = "G";
      6'h23: g = "H";
      6'h24: g = "J";
      6'h25: g = "K";
      6'h26: g = "L";
      6'h27: g = ":";
      6'h2C: g = "Z";
      6'h2D: g = "X";
      6'h2E: g = "C";
      6'h2F: g = "V";
      6'h30: g = "B";
      6'h31: g = "N";
      6'h32: g = "M";
      6'h33: g = "<";
      6'h34: g = ">";
      6'h35: g = "?";
      6'h39: g = " ";
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* design/sc2asc_xlate.sv */
// Combinational decode of one scan code into a character, a raw code or a modifier update.
`default_nettype none

module sc2asc_xlate
  import sc2asc_pkg::*;
(
  input  wire logic [7:0] code,
  input  wire logic       shift_held,
  input  wire logic       caps_lock_on,
  output xlate_res_t      res
);

  logic [7:0] lo;
  logic [7:0] hi;
  logic       is_letter;
  logic       upper;

  // Table lookups only apply to codes below 0x40.
  always_comb begin
    lo = (code[7:6] == 2'b00) ? plain_glyph(code[5:0]) : 8'h00;
    hi = (code[7:6] == 2'b00) ? shifted_glyph(code[5:0]) : 8'h00;
    is_letter = (lo >= "a") && (lo <= "z");
    upper = is_letter ? (shift_held ^ caps_lock_on) : shift_held;
  end

  // Modifiers first, then break codes, then translated or raw make codes.
  always_comb begin
    res.has_result = 1'b0;
    res.kind       = KindAscii;
    res.value      = code;
    res.shift_nxt  = shift_held;
    res.caps_nxt   = caps_lock_on;
    priority if (code == CodeLshiftMake || code == CodeRshiftMake) begin
      res.shift_nxt = 1'b1;
    end else if (code == CodeLshiftBreak || code == CodeRshiftBreak) begin
      res.shift_nxt = 1'b0;
    end else if (code == CodeCapsMake) begin
      res.caps_nxt = ~caps_lock_on;
    end else if (code[7]) begin
      res.has_result = 1'b0;
    end else if (lo == 8'h00) begin
      res.has_result = 1'b1;
      res.kind       = KindRaw;
      res.value      = code;
    end else begin
      res.has_result = 1'b1;
      res.kind       = KindAscii;
      res.value      = upper ? hi : lo;
    end
  end

endmodule

`default_nettype wire

/* design/scancode_to_ascii_decoder.sv */
// Top level of the scan code (set 1) to ASCII decoder.
//
// Usage: scan code bytes enter on the in_ stream, one byte per transfer.
// Each byte yields zero or one result on the out_ stream: out_tdata holds
// the character or the raw code, out_tuser tells which. Shift make and break
// codes and the caps-lock make code update the modifier flags and yield no
// result, as do all other break codes.
// A byte waits in the input register while it is decoded; its result then
// waits in the result register until it transfers. Throughput is one byte
// per cycle while the receiver keeps out_tready high, set by the single
// decode step between the two registers; the modifier flags are updated in
// that same step, so a byte sees the flags left by the byte before it.
// Reset (rst_n low, synchronous) empties both registers and clears shift
// and caps lock. When the receiver holds out_tready low the result waits in
// its register, the input register fills behind it and in_tready falls.
`default_nettype none

module scancode_to_ascii_decoder
  import sc2asc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] scan_code
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] value
  output logic [0:0]      out_tuser   // [0] kind
);

  logic       in_valid_r;
  logic [7:0] in_code_r;
  logic       out_valid_r;
  logic       out_kind_r;
  logic [7:0] out_value_r;
  logic       shift_r;
  logic       caps_r;
  logic       out_free;
  logic       advance;
  xlate_res_t res;

  // Decode of the byte waiting in the input register.
  sc2asc_xlate u_xlate (
    .code         (in_code_r),
    .shift_held   (shift_r),
    .caps_lock_on (caps_r),
    .res          (res)
  );

  // The result register can take a new entry when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_code_r <= in_tdata;
    end
  end

  // Result register and modifier flags, updated as the byte leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      shift_r     <= 1'b0;
      caps_r      <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.has_result;
      shift_r     <= res.shift_nxt;
      caps_r      <= res.caps_nxt;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r  <= res.kind;
      out_value_r <= res.value;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_kind_r;

endmodule

`default_nettype wire

/* design/sc2asc_chk.sv */
// Port checker for the scan code decoder, bound to the top level.
`default_nettype none

module sc2asc_chk
  import sc2asc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [0:0] out_tuser
);

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // A stalled result keeps its value and kind.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Input back-pressure only arises from a stalled result.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without an output stall");

  // Characters and raw make codes both stay below 0x80.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("result value at or above 0x80");

  // A translated character is never zero.
  a_ascii_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == KindAscii) |-> out_tdata != 8'h00)
    else $error("translated character is zero");

endmodule

bind scancode_to_ascii_decoder sc2asc_chk u_sc2asc_chk (.*);

`default_nettype wire
